/* src/flash_erase_range_sequencer_macros.svh */
// Assertion helpers for the flash range erase sequencer checkers.
// Every use expects i_clk and i_rst_n to be visible in the enclosing module.
`ifndef FLASH_ERASE_RANGE_SEQUENCER_MACROS_SVH
`define FLASH_ERASE_RANGE_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FERS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fers check failed");

// The consequent must hold in the cycle after the antecedent.
`define FERS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fers check failed");

`endif

/* src/fers_pkg.sv */
// Shared types, codes and constants of the flash range erase sequencer.
// No dependencies; the other files of the block, all but the assertion macros, refer to it by scoped names.
package fers_pkg;

    localparam int unsigned FLASH_BYTES_DEFAULT = 8388608;

    localparam int unsigned ADDR_W    = 24;
    localparam int unsigned END_W     = 25;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned CFG_IDX_W = 4;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = 2;
    localparam int unsigned QUEUE_CNT_W = 3;
    localparam int unsigned MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_STATUS  = 2'd1,
        OP_TICK    = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_READY = 2'd1,
        PH_ERASE = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ACT_STATUS  = 3'd0,
        ACT_WREN    = 3'd1,
        ACT_ERASE   = 3'd2,
        ACT_DONE    = 3'd3,
        ACT_BAD     = 3'd4,
        ACT_TIMEOUT = 3'd5
    } t_action;

    localparam logic [CFG_IDX_W-1:0] CFG_READY_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_LIMIT = 4'd1;

    localparam logic [MS_W-1:0] READY_LIMIT_RESET = 16'd1000;
    localparam logic [MS_W-1:0] ERASE_LIMIT_RESET = 16'd5000;
    localparam logic [MS_W-1:0] ELAPSED_MAX       = 16'hFFFF;

    localparam logic [7:0] CMD_SECTOR = 8'h20;
    localparam logic [7:0] CMD_BLOCK  = 8'hD8;
    localparam logic [7:0] CMD_WREN   = 8'h06;
    localparam logic [7:0] CMD_RDSR   = 8'h05;

    localparam logic [END_W-1:0] BLOCK_SIZE  = 25'h10000;
    localparam logic [END_W-1:0] SECTOR_SIZE = 25'h01000;
    localparam logic [END_W-1:0] SECTOR_MASK = 25'h00FFF;

    typedef struct packed {
        t_action             action;
        logic [7:0]          command_byte;
        logic [ADDR_W-1:0]   flash_address;
        logic                last;
    } t_result;

    // Results produced by one accepted item, in delivery order.
    typedef struct packed {
        logic [1:0]  count;
        t_result [MAX_RESULTS-1:0] res;
    } t_push;

    function automatic t_result mk_result(t_action act, logic [7:0] cmd,
                                          logic [ADDR_W-1:0] addr, logic fin);
        t_result r;
        r.action        = act;
        r.command_byte  = cmd;
        r.flash_address = addr;
        r.last          = fin;
        return r;
    endfunction

endpackage

/* src/fers_if.sv */
// Handshake channel interfaces of the flash range erase sequencer.
// Depends on fers_pkg for field widths.
interface fers_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [fers_pkg::ADDR_W-1:0]   start_address;
    logic [fers_pkg::ADDR_W-1:0]   byte_count;
    logic [7:0]                    status_byte;

    modport source (output valid, opcode, start_address, byte_count, status_byte,
                    input ready);
    modport sink (input valid, opcode, start_address, byte_count, status_byte,
                  output ready);
endinterface

interface fers_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    action;
    logic [7:0]                    command_byte;
    logic [fers_pkg::ADDR_W-1:0]   flash_address;
    logic                          last;

    modport source (output valid, action, command_byte, flash_address, last,
                    input ready);
    modport sink (input valid, action, command_byte, flash_address, last,
                  output ready);
endinterface

interface fers_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fers_pkg::CFG_IDX_W-1:0]  index;
    logic [fers_pkg::MS_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/fers_core.sv */
// Sequencer state, wait limits and the per-item decision logic.
// Depends on fers_pkg; hands its results to the result queue as a t_push.
module fers_core #(
    parameter int unsigned FLASH_BYTES = fers_pkg::FLASH_BYTES_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [1:0]                      i_opcode,
    input  logic [fers_pkg::ADDR_W-1:0]     i_start_address,
    input  logic [fers_pkg::ADDR_W-1:0]     i_byte_count,
    input  logic [7:0]                      i_status_byte,
    input  logic                            i_cfg_write,
    input  logic [fers_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fers_pkg::MS_W-1:0]       i_cfg_data,
    output fers_pkg::t_push                 o_push
);

    localparam logic [fers_pkg::END_W-1:0] FLASH_LIMIT = fers_pkg::END_W'(FLASH_BYTES);

    fers_pkg::t_phase               r_phase, n_phase;
    logic [fers_pkg::ADDR_W-1:0]    r_cursor, n_cursor;
    logic [fers_pkg::END_W-1:0]     r_end, n_end;
    logic [fers_pkg::MS_W-1:0]      r_elapsed, n_elapsed;
    logic [fers_pkg::MS_W-1:0]      r_ready_limit, r_erase_limit;

    logic                           active;
    logic [fers_pkg::END_W-1:0]     req_sum;
    logic [fers_pkg::END_W-1:0]     remain;
    logic                           use_block;
    logic [fers_pkg::END_W-1:0]     step;
    logic [fers_pkg::MS_W-1:0]      limit;
    logic [7:0]                     erase_cmd;

    assign active    = (r_phase == fers_pkg::PH_READY) || (r_phase == fers_pkg::PH_ERASE);
    assign req_sum   = {1'b0, i_start_address} + {1'b0, i_byte_count};
    // The cursor never passes the end while an operation runs, so this cannot wrap.
    assign remain    = r_end - {1'b0, r_cursor};
    assign use_block = (r_cursor[15:0] == 16'd0) && (remain >= fers_pkg::BLOCK_SIZE);
    assign step      = use_block ? fers_pkg::BLOCK_SIZE : fers_pkg::SECTOR_SIZE;
    assign erase_cmd = use_block ? fers_pkg::CMD_BLOCK : fers_pkg::CMD_SECTOR;
    assign limit     = (r_phase == fers_pkg::PH_READY) ? r_ready_limit : r_erase_limit;

    always_comb begin
        n_phase   = r_phase;
        n_cursor  = r_cursor;
        n_end     = r_end;
        n_elapsed = r_elapsed;
        o_push    = '0;
        if (i_accept) begin
            case (i_opcode)
                fers_pkg::OP_REQUEST: begin
                    o_push.count = 2'd1;
                    if (active || (i_byte_count == '0) || (req_sum > FLASH_LIMIT)) begin
                        o_push.res[0] = fers_pkg::mk_result(fers_pkg::ACT_BAD, 8'h00,
                                                            '0, 1'b1);
                    end else begin
                        n_end     = (req_sum + fers_pkg::SECTOR_MASK) & ~fers_pkg::SECTOR_MASK;
                        n_cursor  = i_start_address & ~fers_pkg::SECTOR_MASK[23:0];
                        n_elapsed = '0;
                        n_phase   = fers_pkg::PH_READY;
                        o_push.res[0] = fers_pkg::mk_result(fers_pkg::ACT_STATUS,
                                                            fers_pkg::CMD_RDSR, '0, 1'b1);
                    end
                end
                fers_pkg::OP_TICK: begin
                    if (active && (r_elapsed != fers_pkg::ELAPSED_MAX)) begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                end
                fers_pkg::OP_STATUS: begin
                    if (active) begin
                        o_push.count = 2'd1;
                        if (i_status_byte[0]) begin
                            if (r_elapsed >= limit) begin
                                n_phase = fers_pkg::PH_IDLE;
                                o_push.res[0] = fers_pkg::mk_result(fers_pkg::ACT_TIMEOUT,
                                                                    8'h00, '0, 1'b1);
                            end else begin
                                o_push.res[0] = fers_pkg::mk_result(fers_pkg::ACT_STATUS,
                                                                    fers_pkg::CMD_RDSR, '0, 1'b1);
                            end
                        end else if (r_phase == fers_pkg::PH_READY) begin
                            o_push.count  = 2'd3;
                            o_push.res[0] = fers_pkg::mk_result(fers_pkg::ACT_WREN,
                                                                fers_pkg::CMD_WREN, '0, 1'b0);
                            o_push.res[1] = fers_pkg::mk_result(fers_pkg::ACT_ERASE,
                                                                erase_cmd, r_cursor, 1'b0);
                            o_push.res[2] = fers_pkg::mk_result(fers_pkg::ACT_STATUS,
                                                                fers_pkg::CMD_RDSR, '0, 1'b1);
                            n_elapsed = '0;
                            n_phase   = fers_pkg::PH_ERASE;
                        end else if (remain <= step) begin
                            n_phase = fers_pkg::PH_IDLE;
                            o_push.res[0] = fers_pkg::mk_result(fers_pkg::ACT_DONE,
                                                                8'h00, '0, 1'b1);
                        end else begin
                            n_cursor  = r_cursor + step[fers_pkg::ADDR_W-1:0];
                            n_elapsed = '0;
                            n_phase   = fers_pkg::PH_READY;
                            o_push.res[0] = fers_pkg::mk_result(fers_pkg::ACT_STATUS,
                                                                fers_pkg::CMD_RDSR, '0, 1'b1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= fers_pkg::PH_IDLE;
            r_cursor      <= '0;
            r_end         <= '0;
            r_elapsed     <= '0;
            r_ready_limit <= fers_pkg::READY_LIMIT_RESET;
            r_erase_limit <= fers_pkg::ERASE_LIMIT_RESET;
        end else begin
            r_phase   <= n_phase;
            r_cursor  <= n_cursor;
            r_end     <= n_end;
            r_elapsed <= n_elapsed;
            if (i_cfg_write && (i_cfg_index == fers_pkg::CFG_READY_LIMIT)) begin
                r_ready_limit <= i_cfg_data;
            end
            if (i_cfg_write && (i_cfg_index == fers_pkg::CFG_ERASE_LIMIT)) begin
                r_erase_limit <= i_cfg_data;
            end
        end
    end

endmodule

/* src/fers_result_queue.sv */
// Four-entry result queue: takes up to three results per cycle, delivers one when the receiver takes it.
// Depends on fers_pkg for the result and push types.
module fers_result_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fers_pkg::t_push  i_push,
    input  logic             i_pop,
    output logic             o_space,
    output logic             o_valid,
    output fers_pkg::t_result o_head
);

    fers_pkg::t_result                   r_mem [fers_pkg::QUEUE_DEPTH];
    logic [fers_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [fers_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [fers_pkg::QUEUE_CNT_W-1:0]    r_count, n_count;
    logic                                pop;

    // Room for a full three-result item must be there before an item is taken.
    assign o_space = (r_count <= fers_pkg::QUEUE_CNT_W'(fers_pkg::QUEUE_DEPTH
                                                       - fers_pkg::MAX_RESULTS));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr + fers_pkg::QUEUE_PTR_W'(i_push.count);
        n_rd_ptr = r_rd_ptr + fers_pkg::QUEUE_PTR_W'(pop);
        n_count  = r_count + fers_pkg::QUEUE_CNT_W'(i_push.count)
                 - fers_pkg::QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < fers_pkg::MAX_RESULTS; k++) begin
            if (k < int'(i_push.count)) begin
                r_mem[r_wr_ptr + fers_pkg::QUEUE_PTR_W'(k)] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* src/flash_erase_range_sequencer.sv */
// Range erase sequencer for a serial NOR flash: top level.
// Depends on fers_pkg, fers_if, fers_core and fers_result_queue.
//
// Channels: i_in carries events (erase request, status byte reply, millisecond
// tick); o_out carries the serial actions to perform (read status, write enable,
// erase with command and address, done, bad request, timeout), with last set on
// the final action caused by one event; i_cfg writes the two wait limits and is
// always ready.
// An event is decided in the cycle it is accepted and its actions are queued;
// with no earlier action waiting, the first is offered on o_out from the next
// cycle, and further ones follow while the receiver takes them.
// Throughput: one event per cycle when each gives at most one action and the
// receiver takes every action. A status reply that starts an erase gives three
// actions. The four-entry result queue sets the limit: i_in.ready stays high
// while at most one action is waiting.
// Reset: i_rst_n is synchronous; it empties the queue, returns the sequencer to
// idle and loads the default limits of 1000 ms and 5000 ms.
// When the receiver stalls, actions wait in the queue and i_in.ready drops once
// two or more are pending; nothing is lost or dropped.
module flash_erase_range_sequencer #(
    parameter int unsigned FLASH_BYTES = fers_pkg::FLASH_BYTES_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fers_in_if.sink       i_in,
    fers_out_if.source    o_out,
    fers_cfg_if.sink      i_cfg
);

    fers_pkg::t_push    push;
    fers_pkg::t_result  head;
    logic               space;
    logic               head_valid;
    logic               in_accept;

    assign i_in.ready  = space;
    assign in_accept   = i_in.valid && space;
    assign i_cfg.ready = 1'b1;

    fers_core #(
        .FLASH_BYTES (FLASH_BYTES)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_opcode        (i_in.opcode),
        .i_start_address (i_in.start_address),
        .i_byte_count    (i_in.byte_count),
        .i_status_byte   (i_in.status_byte),
        .i_cfg_write     (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_push          (push)
    );

    fers_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_space (space),
        .o_valid (head_valid),
        .o_head  (head)
    );

    assign o_out.valid         = head_valid;
    assign o_out.action        = head.action;
    assign o_out.command_byte  = head.command_byte;
    assign o_out.flash_address = head.flash_address;
    assign o_out.last          = head.last;

endmodule

/* src/fers_checker.sv */
// Port-level checks on the action stream of the flash range erase sequencer.
// Depends on fers_pkg and the assertion macros; bound to the top level below.
`include "flash_erase_range_sequencer_macros.svh"

module fers_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [2:0]                    i_action,
    input logic [7:0]                    i_command_byte,
    input logic [fers_pkg::ADDR_W-1:0]   i_flash_address,
    input logic                          i_last
);

    // An erase names a real erase opcode and a sector-aligned address.
    `FERS_ASSERT_NOW(a_erase_form, i_out_valid && (i_action == fers_pkg::ACT_ERASE), ((i_command_byte == fers_pkg::CMD_BLOCK) || (i_command_byte == fers_pkg::CMD_SECTOR)) && (i_flash_address[11:0] == 12'd0))

    `FERS_ASSERT_NOW(a_addr_only_on_erase, i_out_valid && (i_action != fers_pkg::ACT_ERASE), i_flash_address == '0)

    // Write enable is followed back to back by an erase that is not the last action.
    `FERS_ASSERT_NEXT(a_wren_then_erase, i_out_valid && i_out_ready && (i_action == fers_pkg::ACT_WREN), i_out_valid && (i_action == fers_pkg::ACT_ERASE) && !i_last)

    `FERS_ASSERT_NEXT(a_stall_holds, i_out_valid && !i_out_ready, i_out_valid && $stable(i_action) && $stable(i_flash_address) && $stable(i_last))

endmodule

bind flash_erase_range_sequencer fers_checker u_fers_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_action        (o_out.action),
    .i_command_byte  (o_out.command_byte),
    .i_flash_address (o_out.flash_address),
    .i_last          (o_out.last)
);
